// File: hw/rtl/lpd_pkg.sv
package lpd_pkg;

   typedef logic [7:0] mode_type;
   typedef logic [7:0] level_type;
   typedef logic [7:0] phase_type;

   // pattern codes held in the mode registers
   localparam mode_type MODE_OFF      = 8'd0;
   localparam mode_type MODE_BLIP     = 8'd1;
   localparam mode_type MODE_SLOW     = 8'd2;
   localparam mode_type MODE_FAST     = 8'd3;
   localparam mode_type MODE_PWM      = 8'd4;
   localparam mode_type MODE_ON       = 8'd5;
   localparam mode_type MODE_RAMPUP   = 8'd6;
   localparam mode_type MODE_RAMPDOWN = 8'd7;
   localparam mode_type MODE_SINE     = 8'd8;

   // register map
   localparam int CSR_INDEX_W   = 4;
   localparam int REG_MODE0     = 0;
   localparam int REG_LEVEL0    = 4;
   localparam int NUM_CSR_CHANS = 4;

   // phase windows
   localparam phase_type BLIP_END   = 8'd3;
   localparam phase_type HALF_PHASE = 8'd128;
   localparam phase_type FAST_END0  = 8'd43;
   localparam phase_type FAST_BEG1  = 8'd85;
   localparam phase_type FAST_BEG2  = 8'd171;
   localparam phase_type FAST_END2  = 8'd214;

   // phase / 11 as (phase * 373) >> 12, exact for all 8-bit phases
   localparam int        RAMP_PROD_W = 17;
   localparam logic [RAMP_PROD_W-1:0] RAMP_RECIP = 17'd373;
   localparam int        RAMP_SHIFT  = 12;

   localparam int NUM_PINS = 4;

   localparam logic [4:0] SINE_LUT [64] = '{
      5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd20, 5'd21, 5'd22, 5'd22, 5'd23, 5'd23, 5'd23,
      5'd23, 5'd23, 5'd23, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20,
      5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12,
      5'd11, 5'd10, 5'd9,  5'd8,  5'd7,  5'd6,  5'd5,  5'd4,
      5'd3,  5'd2,  5'd2,  5'd1,  5'd1,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd3,  5'd3,
      5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd12
   };

endpackage

// File: hw/rtl/led_pattern_pwm_driver.sv
// Channel  Ports                                   Direction
// req      req_valid req_ready req_tick            in
// rsp      rsp_valid rsp_ready rsp_pin0..3 rsp_phase out
// csr      csr_valid csr_ready csr_index csr_data  in (always ready)
//
// One request per cycle while the response register is free: levels, pin compares and
// counter advance are one pass of logic from the state registers into the response register.
// Reset (synchronous) clears counters, levels, mode and level registers.
// A request is taken whenever the response register is empty or being drained,
// so a stalled response only holds off requests while it is still pending.
module led_pattern_pwm_driver
   import lpd_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int PWM_STEPS    = 24
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_tick,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_pin0,
   output logic                   rsp_pin1,
   output logic                   rsp_pin2,
   output logic                   rsp_pin3,
   output logic [7:0]             rsp_phase,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   // only the first four channels have registers and pins
   localparam int ACT_CH  = (NUM_CHANNELS > NUM_CSR_CHANS) ? NUM_CSR_CHANS : NUM_CHANNELS;
   localparam int CNT_W   = $clog2(PWM_STEPS);
   localparam level_type FULL_LEVEL = 8'(PWM_STEPS);
   localparam logic [CNT_W:0] CNT_WRAP = (CNT_W+1)'(PWM_STEPS);

   mode_type   chan_mode_ff  [ACT_CH];
   level_type  chan_lvreg_ff [ACT_CH];
   level_type  chan_level_ff [ACT_CH];
   level_type  chan_level_in [ACT_CH];

   logic [CNT_W-1:0] pwm_count_ff, pwm_count_in;
   logic             half_div_ff, half_div_in;
   phase_type        phase_ff, phase_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_PINS-1:0] pins_ff, pins_in;
   phase_type        rsp_phase_ff;

   logic             req_accept;
   logic             fast_on;
   logic [RAMP_PROD_W-1:0] ramp_prod;
   level_type        ramp_q;
   level_type        sine_val;
   logic [CNT_W:0]   cnt_inc;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // phase-derived values shared by all channels
   always_comb begin
      fast_on = (phase_ff < FAST_END0)
             || (phase_ff >= FAST_BEG1 && phase_ff < HALF_PHASE)
             || (phase_ff >= FAST_BEG2 && phase_ff < FAST_END2);
      ramp_prod = RAMP_PROD_W'(phase_ff) * RAMP_RECIP;
      ramp_q    = 8'(ramp_prod >> RAMP_SHIFT);
      sine_val  = {3'b000, SINE_LUT[phase_ff[7:2]]};
   end

   // per-channel level; unknown modes hold the previous level
   always_comb begin
      for (int c = 0; c < ACT_CH; c++) begin
         chan_level_in[c] = chan_level_ff[c];
         unique case (chan_mode_ff[c])
            MODE_OFF:      chan_level_in[c] = '0;
            MODE_BLIP:     chan_level_in[c] = (phase_ff < BLIP_END) ? FULL_LEVEL : '0;
            MODE_SLOW:     chan_level_in[c] = (phase_ff < HALF_PHASE) ? FULL_LEVEL : '0;
            MODE_FAST:     chan_level_in[c] = fast_on ? FULL_LEVEL : '0;
            MODE_PWM:      chan_level_in[c] = chan_lvreg_ff[c];
            MODE_ON:       chan_level_in[c] = FULL_LEVEL;
            MODE_RAMPUP:   chan_level_in[c] = ramp_q;
            MODE_RAMPDOWN: chan_level_in[c] = FULL_LEVEL - ramp_q;
            MODE_SINE:     chan_level_in[c] = sine_val;
            default:       chan_level_in[c] = chan_level_ff[c];
         endcase
      end
   end

   // pin is high while the PWM count has reached the fresh level
   always_comb begin
      pins_in = '0;
      for (int c = 0; c < ACT_CH; c++) begin
         pins_in[c] = (8'(pwm_count_ff) >= chan_level_in[c]);
      end
   end

   // counter chain: PWM count wraps, divide by two, then phase advances
   always_comb begin
      cnt_inc      = {1'b0, pwm_count_ff} + 1'b1;
      pwm_count_in = pwm_count_ff;
      half_div_in  = half_div_ff;
      phase_in     = phase_ff;
      if (req_tick) begin
         if (cnt_inc >= CNT_WRAP) begin
            pwm_count_in = '0;
            half_div_in  = !half_div_ff;
            if (half_div_ff) begin
               phase_in = phase_ff + 8'd1;
            end
         end else begin
            pwm_count_in = cnt_inc[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pwm_count_ff <= '0;
         half_div_ff  <= 1'b0;
         phase_ff     <= '0;
         for (int c = 0; c < ACT_CH; c++) begin
            chan_level_ff[c] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            pwm_count_ff <= pwm_count_in;
            half_div_ff  <= half_div_in;
            phase_ff     <= phase_in;
            for (int c = 0; c < ACT_CH; c++) begin
               chan_level_ff[c] <= chan_level_in[c];
            end
         end
      end
   end

   // configuration registers; writes beyond the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < ACT_CH; c++) begin
            chan_mode_ff[c]  <= MODE_OFF;
            chan_lvreg_ff[c] <= '0;
         end
      end else if (csr_valid) begin
         for (int c = 0; c < ACT_CH; c++) begin
            if (csr_index == CSR_INDEX_W'(REG_MODE0 + c)) begin
               chan_mode_ff[c] <= csr_data;
            end
            if (csr_index == CSR_INDEX_W'(REG_LEVEL0 + c)) begin
               chan_lvreg_ff[c] <= csr_data;
            end
         end
      end
   end

   // response payload, loaded with each request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pins_ff      <= pins_in;
         rsp_phase_ff <= phase_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pin0  = pins_ff[0];
   assign rsp_pin1  = pins_ff[1];
   assign rsp_pin2  = pins_ff[2];
   assign rsp_pin3  = pins_ff[3];
   assign rsp_phase = rsp_phase_ff;

endmodule
